FILE: design/qcac_pkg.sv
// Shared types and constants for the quadrilateral corner angle checker.
// No dependencies; imported by the input interface, the corner lane and the top level.
`timescale 1ns / 1ps
`default_nettype none

package qcac_pkg;

    // Default vertex coordinate width (signed pixels)
    localparam int COORD_BITS_DEF = 12;

    // Limit registers: Q14 cosines, 16 bits signed
    localparam int COS_W     = 16;
    // c*c for any 16-bit signed c is at most 2^30
    localparam int C2_W      = 31;
    // Q14 squared on the limit side gives Q28; the dot product side is lifted to match
    localparam int Q_SHIFT   = 28;

    // Reset limits: +/-14189 (about 30 and 150 degrees), both square to the same value
    localparam logic [C2_W-1:0] C2_RST = 31'd201327721;

    // Register stages inside one corner lane, plus the output register at the top
    localparam int LANE_STG  = 7;
    localparam int NSTG      = LANE_STG + 1;

    localparam int CFG_IDX_W = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COS_LOWER = 1'b0,
        CFG_COS_UPPER = 1'b1
    } t_cfg_idx;

    // Limits as held in hardware: sign of the cosine and its square
    typedef struct packed {
        logic            lo_neg;
        logic [C2_W-1:0] lo_c2;
        logic            up_neg;
        logic [C2_W-1:0] up_c2;
    } t_lim;

endpackage

`default_nettype wire

FILE: design/qcac_in_if.sv
// Input channel: valid/ready with the four vertices of one quadrilateral.
// Depends on qcac_pkg for the default coordinate width.
`timescale 1ns / 1ps
`default_nettype none

interface qcac_in_if
    import qcac_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] x0;
    logic signed [COORD_BITS-1:0] y0;
    logic signed [COORD_BITS-1:0] x1;
    logic signed [COORD_BITS-1:0] y1;
    logic signed [COORD_BITS-1:0] x2;
    logic signed [COORD_BITS-1:0] y2;
    logic signed [COORD_BITS-1:0] x3;
    logic signed [COORD_BITS-1:0] y3;

    modport source (output valid, x0, y0, x1, y1, x2, y2, x3, y3, input ready);
    modport sink   (input valid, x0, y0, x1, y1, x2, y2, x3, y3, output ready);
endinterface

`default_nettype wire

FILE: design/qcac_out_if.sv
// Output channel: valid/ready with the pass flag and the per-corner masks.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface qcac_out_if;
    logic       valid;
    logic       ready;
    logic       passed;
    logic [3:0] too_sharp_mask;
    logic [3:0] too_wide_mask;

    modport source (output valid, passed, too_sharp_mask, too_wide_mask, input ready);
    modport sink   (input valid, passed, too_sharp_mask, too_wide_mask, output ready);
endinterface

`default_nettype wire

FILE: design/qcac_corner.sv
// One corner lane: edge vectors, dot product, squared lengths and the two
// cosine-limit comparisons, in seven register stages. Depends on qcac_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qcac_corner
    import qcac_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic [LANE_STG-1:0]          i_en,
    input  wire t_lim                         i_lim,
    input  wire logic signed [COORD_BITS-1:0] i_px,
    input  wire logic signed [COORD_BITS-1:0] i_py,
    input  wire logic signed [COORD_BITS-1:0] i_vx,
    input  wire logic signed [COORD_BITS-1:0] i_vy,
    input  wire logic signed [COORD_BITS-1:0] i_qx,
    input  wire logic signed [COORD_BITS-1:0] i_qy,
    output logic                              o_sharp,
    output logic                              o_wide
);

    localparam int DW  = COORD_BITS + 1;      // edge component
    localparam int PW  = 2 * COORD_BITS + 2;  // component product
    localparam int SW  = 2 * COORD_BITS + 3;  // dot product
    localparam int LW  = 2 * COORD_BITS + 2;  // squared length
    localparam int HW  = LW;                  // half of the length product
    localparam int QW  = 2 * LW;              // d^2 and |A|^2 |B|^2
    localparam int TPW = C2_W + HW;           // partial limit product
    localparam int TW  = C2_W + QW;           // full limit product, compare width

    // {positive, negative} sign of sign(d)*S - sign(c)*T from magnitudes
    function automatic logic [1:0] f_order(input logic dn, input logic cn,
                                           input logic gt, input logic lt,
                                           input logic zz);
        logic p;
        logic n;
        if (!dn && !cn) begin
            p = gt;
            n = lt;
        end else if (dn && cn) begin
            p = lt;
            n = gt;
        end else if (!dn) begin
            p = !zz;
            n = 1'b0;
        end else begin
            p = 1'b0;
            n = 1'b1;
        end
        return {p, n};
    endfunction

    // stage 1: edge vectors
    logic signed [DW-1:0] r_ax, r_ay, r_bx, r_by;
    // stage 2: products
    logic signed [PW-1:0] r_abx, r_aby, r_aax, r_aay, r_bbx, r_bby;
    logic                 r_deg2;
    // stage 3: sums
    logic signed [SW-1:0] r_d;
    logic [LW-1:0]        r_la, r_lb;
    logic                 r_deg3;
    // stage 4: squares
    logic signed [2*SW-1:0] w_dd;
    logic [QW-1:0]        r_dsq4, r_l;
    logic                 r_dneg4, r_deg4;
    // stage 5: limit partial products
    logic [TPW-1:0]       r_tlo_l, r_thi_l, r_tlo_u, r_thi_u;
    logic [QW-1:0]        r_dsq5;
    logic                 r_dneg5, r_deg5;
    // stage 6: full magnitudes
    logic [TW-1:0]        r_tm_l, r_tm_u, r_sm;
    logic                 r_dneg6, r_deg6;
    // stage 7: flags
    logic                 r_sharp, r_wide;
    logic [1:0]           w_ord_l, w_ord_u;

    assign w_dd = r_d * r_d;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_ax <= DW'(i_px) - DW'(i_vx);
            r_ay <= DW'(i_py) - DW'(i_vy);
            r_bx <= DW'(i_qx) - DW'(i_vx);
            r_by <= DW'(i_qy) - DW'(i_vy);
        end
        if (i_en[1]) begin
            r_abx  <= PW'(r_ax) * PW'(r_bx);
            r_aby  <= PW'(r_ay) * PW'(r_by);
            r_aax  <= PW'(r_ax) * PW'(r_ax);
            r_aay  <= PW'(r_ay) * PW'(r_ay);
            r_bbx  <= PW'(r_bx) * PW'(r_bx);
            r_bby  <= PW'(r_by) * PW'(r_by);
            r_deg2 <= (r_ax == '0 && r_ay == '0) || (r_bx == '0 && r_by == '0);
        end
        if (i_en[2]) begin
            r_d    <= SW'(r_abx) + SW'(r_aby);
            r_la   <= LW'($unsigned(r_aax)) + LW'($unsigned(r_aay));
            r_lb   <= LW'($unsigned(r_bbx)) + LW'($unsigned(r_bby));
            r_deg3 <= r_deg2;
        end
        if (i_en[3]) begin
            r_dsq4  <= w_dd[QW-1:0];
            r_l     <= QW'(r_la) * QW'(r_lb);
            r_dneg4 <= r_d[SW-1];
            r_deg4  <= r_deg3;
        end
        if (i_en[4]) begin
            r_tlo_l <= TPW'(i_lim.lo_c2) * TPW'(r_l[HW-1:0]);
            r_thi_l <= TPW'(i_lim.lo_c2) * TPW'(r_l[QW-1:HW]);
            r_tlo_u <= TPW'(i_lim.up_c2) * TPW'(r_l[HW-1:0]);
            r_thi_u <= TPW'(i_lim.up_c2) * TPW'(r_l[QW-1:HW]);
            r_dsq5  <= r_dsq4;
            r_dneg5 <= r_dneg4;
            r_deg5  <= r_deg4;
        end
        if (i_en[5]) begin
            r_tm_l  <= (TW'(r_thi_l) << HW) + TW'(r_tlo_l);
            r_tm_u  <= (TW'(r_thi_u) << HW) + TW'(r_tlo_u);
            r_sm    <= TW'(r_dsq5) << Q_SHIFT;
            r_dneg6 <= r_dneg5;
            r_deg6  <= r_deg5;
        end
        if (i_en[6]) begin
            r_sharp <= !r_deg6 && w_ord_l[1];
            r_wide  <= !r_deg6 && w_ord_u[0];
        end
    end

    assign w_ord_l = f_order(r_dneg6, i_lim.lo_neg, r_sm > r_tm_l, r_sm < r_tm_l,
                             r_sm == '0 && r_tm_l == '0);
    assign w_ord_u = f_order(r_dneg6, i_lim.up_neg, r_sm > r_tm_u, r_sm < r_tm_u,
                             r_sm == '0 && r_tm_u == '0);

    assign o_sharp = r_sharp;
    assign o_wide  = r_wide;

    // zero-length edge never flags
    a_deg_clear: assert property (@(posedge i_clk)
        i_en[6] && r_deg6 |=> !r_sharp && !r_wide)
        else $error("degenerate corner flagged");

    // obtuse dot product cannot be sharper than a non-negative cosine limit
    a_neg_not_sharp: assert property (@(posedge i_clk)
        i_en[6] && r_dneg6 && !i_lim.lo_neg |=> !r_sharp)
        else $error("negative dot product flagged too sharp");

    // non-negative dot product cannot be wider than a negative cosine limit
    a_pos_not_wide: assert property (@(posedge i_clk)
        i_en[6] && !r_dneg6 && i_lim.up_neg |=> !r_wide)
        else $error("non-negative dot product flagged too wide");

endmodule

`default_nettype wire

FILE: design/quad_corner_angle_check.sv
// Top level of the quadrilateral corner angle checker: limit registers,
// pipeline control and four corner lanes. Depends on qcac_pkg, the two
// channel interfaces and qcac_corner.
`timescale 1ns / 1ps
`default_nettype none

// Checks all four corner angles of a quadrilateral against a lower and an
// upper limit. Each input transfer carries the four vertices; each produces
// exactly one output transfer with the pass flag and two 4-bit masks (bit i
// for the corner at vertex i). Throughput is one item per clock while the
// output side does not stall: the four corners run in parallel lanes of
// seven register stages each, followed by the output register. Each stage
// accepts new data whenever it is empty or its successor moves, so bubbles
// are squeezed out and the input keeps taking items while a finished result
// waits, as long as some stage is still empty. The limits are written as Q14
// cosines through the register port (index 0: lower limit, index 1: upper
// limit), stored as sign plus square, and must only be changed while the
// pipeline is empty. Angles are compared without square roots:
// sign(d)*d^2*2^28 against sign(c)*c^2*|A|^2*|B|^2, exactly; equality is
// not flagged and a corner with a zero-length edge is never flagged. There
// is no memory and no start-up pass after reset.

module quad_corner_angle_check
    import qcac_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    qcac_in_if.sink                   i_in,
    qcac_out_if.source                o_out,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [COS_W-1:0]     i_cfg_wdata
);

    // ---------------- limit registers ----------------
    t_lim                      r_lim;
    logic signed [2*COS_W-1:0] w_csq;

    assign w_csq = $signed(i_cfg_wdata) * $signed(i_cfg_wdata);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim.lo_neg <= 1'b0;
            r_lim.lo_c2  <= C2_RST;
            r_lim.up_neg <= 1'b1;
            r_lim.up_c2  <= C2_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_COS_LOWER: begin
                    r_lim.lo_neg <= i_cfg_wdata[COS_W-1];
                    r_lim.lo_c2  <= w_csq[C2_W-1:0];
                end
                CFG_COS_UPPER: begin
                    r_lim.up_neg <= i_cfg_wdata[COS_W-1];
                    r_lim.up_c2  <= w_csq[C2_W-1:0];
                end
                default: begin
                    r_lim <= r_lim;
                end
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    // w_en[k]: stage k register loads this cycle. A stage loads when empty
    // or when its contents move on; the last stage moves on an output transfer.
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] w_en;

    assign w_en[NSTG-1] = !r_vld[NSTG-1] || o_out.ready;

    for (genvar k = 0; k < NSTG - 1; k++) begin : g_en
        assign w_en[k] = !r_vld[k] || w_en[k+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_in.valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign i_in.ready = w_en[0];

    // ---------------- corner lanes ----------------
    logic signed [COORD_BITS-1:0] w_x [4];
    logic signed [COORD_BITS-1:0] w_y [4];
    logic [3:0]                   w_sharp;
    logic [3:0]                   w_wide;

    assign w_x[0] = i_in.x0;
    assign w_y[0] = i_in.y0;
    assign w_x[1] = i_in.x1;
    assign w_y[1] = i_in.y1;
    assign w_x[2] = i_in.x2;
    assign w_y[2] = i_in.y2;
    assign w_x[3] = i_in.x3;
    assign w_y[3] = i_in.y3;

    // corner i sits between its predecessor and successor vertex, mod 4
    for (genvar i = 0; i < 4; i++) begin : g_lane
        localparam int P = (i + 3) % 4;
        localparam int Q = (i + 1) % 4;

        qcac_corner #(
            .COORD_BITS (COORD_BITS)
        ) u_corner (
            .i_clk   (i_clk),
            .i_en    (w_en[LANE_STG-1:0]),
            .i_lim   (r_lim),
            .i_px    (w_x[P]),
            .i_py    (w_y[P]),
            .i_vx    (w_x[i]),
            .i_vy    (w_y[i]),
            .i_qx    (w_x[Q]),
            .i_qy    (w_y[Q]),
            .o_sharp (w_sharp[i]),
            .o_wide  (w_wide[i])
        );
    end

    // ---------------- output register ----------------
    logic       r_pass;
    logic [3:0] r_sharp_m;
    logic [3:0] r_wide_m;

    always_ff @(posedge i_clk) begin
        if (w_en[NSTG-1]) begin
            r_sharp_m <= w_sharp;
            r_wide_m  <= w_wide;
            r_pass    <= (w_sharp == 4'b0) && (w_wide == 4'b0);
        end
    end

    assign o_out.valid          = r_vld[NSTG-1];
    assign o_out.passed         = r_pass;
    assign o_out.too_sharp_mask = r_sharp_m;
    assign o_out.too_wide_mask  = r_wide_m;

    // ---------------- checks ----------------
    // an input transfer lands in the first stage
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> r_vld[0])
        else $error("accepted item missing from first stage");

    // a held stage keeps its item (nothing dropped under backpressure)
    for (genvar k = 0; k < NSTG - 1; k++) begin : g_chk
        a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            r_vld[k] && !w_en[k+1] |=> r_vld[k])
            else $error("item lost in a stalled stage");
    end

    // nothing leaves straight after reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("output valid after reset");

endmodule

`default_nettype wire
